>>> rtl/core/tcsw_pkg.sv
// Package for the text console scroll writer.
// Holds the widths, item codes, character constants, queued command type and back-end state type.
// No dependencies.
package tcsw_pkg;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_PUT   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    typedef enum logic [2:0] {
        OP_CHAR,
        OP_NEWLINE,
        OP_RETURN,
        OP_PUT,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] char_code;
        logic              first;
        logic              in_range;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [ATTR_W-1:0] attr;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_TEXT,
        ST_SCROLL_MOVE,
        ST_SCROLL_BLANK,
        ST_CLEAR,
        ST_READ,
        ST_DONE
    } back_state_t;

endpackage

>>> rtl/core/tcsw_front.sv
// Front end: accepts input beats, decodes them into queued commands.
// Depends on tcsw_pkg.
module tcsw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_kind,
    input  logic [tcsw_pkg::CHAR_W-1:0]  s_char_code,
    input  logic                         s_first_of_string,
    input  logic [tcsw_pkg::ROW_W-1:0]   s_row_index,
    input  logic [tcsw_pkg::COL_W-1:0]   s_column_index,
    input  logic [tcsw_pkg::ATTR_W-1:0]  s_cell_attribute,
    input  logic                         init_busy,
    input  logic                         q_ready,
    output logic                         q_push,
    output tcsw_pkg::cmd_t               q_cmd
);
    import tcsw_pkg::*;

    assign s_ready = q_ready && !init_busy;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_cmd.char_code = s_char_code;
        q_cmd.first     = s_first_of_string;
        q_cmd.row       = s_row_index;
        q_cmd.col       = s_column_index;
        q_cmd.attr      = s_cell_attribute;
        q_cmd.in_range  = (int'(s_row_index) < ROWS) && (int'(s_column_index) < COLUMNS);
        case (s_kind)
            KIND_TEXT: begin
                if (s_char_code == CH_NEWLINE) begin
                    q_cmd.op = OP_NEWLINE;
                end else if (s_char_code == CH_RETURN) begin
                    q_cmd.op = OP_RETURN;
                end else begin
                    q_cmd.op = OP_CHAR;
                end
            end
            KIND_PUT:   q_cmd.op = OP_PUT;
            KIND_CLEAR: q_cmd.op = OP_CLEAR;
            KIND_READ:  q_cmd.op = OP_READ;
            default:    q_cmd.op = OP_READ;
        endcase
    end

endmodule

>>> rtl/core/tcsw_queue.sv
// Two-entry command queue between front end and back end.
// Depends on tcsw_pkg.
module tcsw_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tcsw_pkg::cmd_t push_cmd,
    output logic           push_ready,
    input  logic           pop,
    output logic           pop_valid,
    output tcsw_pkg::cmd_t pop_cmd
);
    import tcsw_pkg::*;

    cmd_t       entries_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/core/tcsw_back.sv
// Back end: screen memory, cursor, scroll/clear sequencer and result register.
// Depends on tcsw_pkg.
module tcsw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [tcsw_pkg::ATTR_W-1:0]  cfg_wdata,
    input  logic                         q_valid,
    input  tcsw_pkg::cmd_t               q_cmd,
    output logic                         q_pop,
    output logic                         init_busy,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tcsw_pkg::ROW_W-1:0]   m_cursor_row,
    output logic [tcsw_pkg::COL_W-1:0]   m_cursor_column,
    output logic [tcsw_pkg::CELL_W-1:0]  m_read_data
);
    import tcsw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_MOVE  = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLUMNS);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] mem_rdata_reg;
    logic [ADDR_W-1:0] rd_addr;

    back_state_t       state_reg;
    back_state_t       state_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic              ret_text_reg;
    logic              ret_text_next;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] cnt_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [CELL_W-1:0] rd_data_reg;
    logic [CELL_W-1:0] rd_data_next;
    logic [ATTR_W-1:0] attr_reg;
    logic              wr_en_reg;
    logic              wr_en_next;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [ADDR_W-1:0] wr_addr_next;
    logic [CELL_W-1:0] wr_data_reg;
    logic [CELL_W-1:0] wr_data_next;
    logic              wr_from_read_reg;
    logic              wr_from_read_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [ROW_W-1:0]  m_row_reg;
    logic [ROW_W-1:0]  m_row_next;
    logic [COL_W-1:0]  m_col_reg;
    logic [COL_W-1:0]  m_col_next;
    logic [CELL_W-1:0] m_data_reg;
    logic [CELL_W-1:0] m_data_next;

    logic              last_row;
    logic              last_col;
    logic              forced;
    logic              out_free;
    logic [ADDR_W-1:0] cursor_addr;
    logic [ADDR_W-1:0] target_addr;
    logic [CELL_W-1:0] blank;

    assign last_row    = (row_reg == LAST_ROW);
    assign last_col    = (col_reg == LAST_COL);
    assign forced      = q_cmd.first && (col_reg != '0) && (q_cmd.op != OP_NEWLINE);
    assign out_free    = !m_valid_reg || m_ready;
    assign cursor_addr = ADDR_W'(int'(row_reg) * COLUMNS + int'(col_reg));
    assign target_addr = ADDR_W'(int'(q_cmd.row) * COLUMNS + int'(q_cmd.col));
    assign blank       = {attr_reg, CH_SPACE};

    assign init_busy       = (state_reg == ST_INIT);
    assign q_pop           = (state_reg == ST_IDLE) && q_valid;
    assign rd_addr         = (state_reg == ST_SCROLL_MOVE) ? cnt_reg + ROW_STEP : target_addr;
    assign m_valid         = m_valid_reg;
    assign m_cursor_row    = m_row_reg;
    assign m_cursor_column = m_col_reg;
    assign m_read_data     = m_data_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (cnt_reg == LAST_CELL) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (q_valid) begin
                    case (q_cmd.op)
                        OP_CHAR, OP_NEWLINE, OP_RETURN: begin
                            state_next = (forced && last_row) ? ST_SCROLL_MOVE : ST_TEXT;
                        end
                        OP_PUT:   state_next = ST_DONE;
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_READ:  state_next = ST_READ;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_TEXT: begin
                case (cmd_reg.op)
                    OP_NEWLINE: state_next = last_row ? ST_SCROLL_MOVE : ST_DONE;
                    OP_RETURN:  state_next = ST_DONE;
                    default:    state_next = (last_row && last_col) ? ST_SCROLL_MOVE : ST_DONE;
                endcase
            end
            ST_SCROLL_MOVE: begin
                if (cnt_reg == LAST_MOVE) state_next = ST_SCROLL_BLANK;
            end
            ST_SCROLL_BLANK: begin
                if (cnt_reg == LAST_CELL) state_next = ret_text_reg ? ST_TEXT : ST_DONE;
            end
            ST_CLEAR: begin
                if (cnt_reg == LAST_CELL) state_next = ST_DONE;
            end
            ST_READ: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd_next          = cmd_reg;
        ret_text_next     = ret_text_reg;
        cnt_next          = cnt_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        rd_data_next      = rd_data_reg;
        wr_en_next        = 1'b0;
        wr_addr_next      = cnt_reg;
        wr_data_next      = blank;
        wr_from_read_next = 1'b0;
        m_valid_next      = m_valid_reg && !m_ready;
        m_row_next        = m_row_reg;
        m_col_next        = m_col_reg;
        m_data_next       = m_data_reg;
        case (state_reg)
            ST_INIT: begin
                wr_en_next   = 1'b1;
                wr_data_next = {ATTR_RESET, CH_SPACE};
                cnt_next     = cnt_reg + 1'b1;
            end
            ST_IDLE: begin
                if (q_valid) begin
                    cmd_next     = q_cmd;
                    rd_data_next = '0;
                    case (q_cmd.op)
                        OP_CHAR, OP_NEWLINE, OP_RETURN: begin
                            if (forced) begin
                                col_next      = '0;
                                ret_text_next = 1'b1;
                                cnt_next      = '0;
                                row_next      = last_row ? row_reg : row_reg + 1'b1;
                            end
                        end
                        OP_PUT: begin
                            wr_en_next   = q_cmd.in_range;
                            wr_addr_next = target_addr;
                            wr_data_next = {q_cmd.attr, q_cmd.char_code};
                        end
                        OP_CLEAR: begin
                            row_next = '0;
                            col_next = '0;
                            cnt_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TEXT: begin
                ret_text_next = 1'b0;
                cnt_next      = '0;
                case (cmd_reg.op)
                    OP_NEWLINE: begin
                        col_next = '0;
                        row_next = last_row ? row_reg : row_reg + 1'b1;
                    end
                    OP_RETURN: col_next = '0;
                    default: begin
                        wr_en_next   = 1'b1;
                        wr_addr_next = cursor_addr;
                        wr_data_next = {attr_reg, cmd_reg.char_code};
                        if (last_col) begin
                            col_next = '0;
                            row_next = last_row ? row_reg : row_reg + 1'b1;
                        end else begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                endcase
            end
            ST_SCROLL_MOVE: begin
                wr_en_next        = 1'b1;
                wr_from_read_next = 1'b1;
                cnt_next          = (cnt_reg == LAST_MOVE) ? BOTTOM_ROW : cnt_reg + 1'b1;
            end
            ST_SCROLL_BLANK, ST_CLEAR: begin
                wr_en_next = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
            end
            ST_READ: begin
                rd_data_next = cmd_reg.in_range ? mem_rdata_reg : '0;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_row_next   = row_reg;
                    m_col_next   = col_reg;
                    m_data_next  = rd_data_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            cnt_reg      <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            ret_text_reg <= 1'b0;
            wr_en_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
            attr_reg     <= ATTR_RESET;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            ret_text_reg <= ret_text_next;
            wr_en_reg    <= wr_en_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                attr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg          <= cmd_next;
        rd_data_reg      <= rd_data_next;
        wr_addr_reg      <= wr_addr_next;
        wr_data_reg      <= wr_data_next;
        wr_from_read_reg <= wr_from_read_next;
        m_row_reg        <= m_row_next;
        m_col_reg        <= m_col_next;
        m_data_reg       <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en_reg) begin
            mem[wr_addr_reg] <= wr_from_read_reg ? mem_rdata_reg : wr_data_reg;
        end
        mem_rdata_reg <= mem[rd_addr];
    end

endmodule

>>> rtl/core/text_console_scroll_writer_top.sv
// Top level of the text console scroll writer.
// Instantiates tcsw_front, tcsw_queue and tcsw_back; depends on tcsw_pkg.
//
//   channel  direction  handshake           payload
//   s_       in         s_valid / s_ready   kind, char, first flag, row, column, attr
//   m_       out        m_valid / m_ready   cursor row, cursor column, read data
//   cfg_     in         cfg_we              text attribute
//
// Text character and cell read go through the back-end sequencer as dispatch, execute
// and load result register; position write as dispatch and load result.
// A scroll moves one cell per cycle through the one read port and one write port
// of the screen memory, then writes one bottom-row blank per cycle.
// Clear writes one blank per cycle to every cell.
// After reset the screen memory is blanked with s_ready low.
// The two-entry queue takes up to two beats while the result register waits on m_ready.
module text_console_scroll_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [tcsw_pkg::ATTR_W-1:0]  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_kind,
    input  logic [tcsw_pkg::CHAR_W-1:0]  s_char_code,
    input  logic                         s_first_of_string,
    input  logic [tcsw_pkg::ROW_W-1:0]   s_row_index,
    input  logic [tcsw_pkg::COL_W-1:0]   s_column_index,
    input  logic [tcsw_pkg::ATTR_W-1:0]  s_cell_attribute,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tcsw_pkg::ROW_W-1:0]   m_cursor_row,
    output logic [tcsw_pkg::COL_W-1:0]   m_cursor_column,
    output logic [tcsw_pkg::CELL_W-1:0]  m_read_data
);
    import tcsw_pkg::*;

    logic init_busy;
    logic q_ready;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_valid;
    logic q_pop;
    cmd_t q_pop_cmd;

    tcsw_front #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_char_code      (s_char_code),
        .s_first_of_string(s_first_of_string),
        .s_row_index      (s_row_index),
        .s_column_index   (s_column_index),
        .s_cell_attribute (s_cell_attribute),
        .init_busy        (init_busy),
        .q_ready          (q_ready),
        .q_push           (q_push),
        .q_cmd            (q_push_cmd)
    );

    tcsw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .push_ready(q_ready),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_pop_cmd)
    );

    tcsw_back #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .q_valid        (q_valid),
        .q_cmd          (q_pop_cmd),
        .q_pop          (q_pop),
        .init_busy      (init_busy),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cursor_row   (m_cursor_row),
        .m_cursor_column(m_cursor_column),
        .m_read_data    (m_read_data)
    );

endmodule

>>> rtl/core/tcsw_checker.sv
// Port-level checker for the text console scroll writer, bound to the top level.
// Depends on tcsw_pkg.
module tcsw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [tcsw_pkg::ROW_W-1:0]   m_cursor_row,
    input logic [tcsw_pkg::COL_W-1:0]   m_cursor_column,
    input logic [tcsw_pkg::CELL_W-1:0]  m_read_data
);
    import tcsw_pkg::*;

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cursor_row)
            && $stable(m_cursor_column) && $stable(m_read_data))
        else $error("result beat changed while stalled");

    a_column_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> int'(m_cursor_column) < COLUMNS)
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> int'(m_cursor_row) < ROWS)
        else $error("cursor row out of range");

    a_init_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("input taken or result shown during screen blanking");

endmodule

bind text_console_scroll_writer_top tcsw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_tcsw_checker (.*);
